@@ rtl/rlcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlcc_pkg
// Types, codes and the brightness scaling function for the RGB colour cycler.
// ----------------------------------------------------------------------------
package rlcc_pkg;

	localparam int NUM_CH = 3;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] chan_t;
	typedef logic [2:0] reg_idx_t;

	localparam cmd_t CMD_TICK    = 2'd0;
	localparam cmd_t CMD_SET_ALL = 2'd1;
	localparam cmd_t CMD_SET_ONE = 2'd2;

	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;

	localparam reg_idx_t REG_RED_GAIN    = 3'd0;
	localparam reg_idx_t REG_GREEN_GAIN  = 3'd1;
	localparam reg_idx_t REG_BLUE_GAIN   = 3'd2;
	localparam reg_idx_t REG_CYCLE_SPEED = 3'd3;
	localparam reg_idx_t REG_CYCLE_EN    = 3'd4;

	localparam logic [7:0] FULL_SCALE     = 8'd255;
	localparam logic [7:0] SPEED_AT_RESET = 8'd175;

	typedef struct packed {
		logic [NUM_CH-1:0][7:0] gain;
		logic [7:0]             speed;
		logic                   enable;
	} cfg_t;

	typedef struct packed {
		cmd_t                   cmd;
		chan_t                  channel_sel;
		logic [7:0]             level;
		logic [NUM_CH-1:0][7:0] rgb_level;
	} item_t;

	// level * gain / 255, truncated. The add-and-shift form is exact for
	// every product of two 8-bit values.
	function automatic logic [7:0] scale(input logic [7:0] lvl, input logic [7:0] gain);
		logic [15:0] prod;
		logic [16:0] sum;
		prod = 16'(lvl) * 16'(gain);
		sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
		return sum[15:8];
	endfunction

endpackage

@@ rtl/rgb_led_colour_cycler.sv @@
// ----------------------------------------------------------------------------
// rgb_led_colour_cycler
// Colour cycler with per-channel brightness scaling, stream in and stream out.
// ----------------------------------------------------------------------------
// Every input word produces exactly one output word carrying the three scaled
// duties after that word and a flag that is set when a timer tick made a
// ramp step. The block takes one word per clock while the output is not
// stalled; a word passes an input register, then the multiply-and-scale path
// and then a result register, from which its result is offered. The input
// register can take a new word while the previous result still waits, if it
// is empty. The user must write the registers over APB only while no word is
// in flight; the block itself does not enforce it.
module rgb_led_colour_cycler import rlcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // level, red_level, green_level, blue_level
	input  logic [3:0]  s_axis_tuser,  // cmd, channel_sel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_duty, green_duty, blue_duty
	output logic        m_axis_tuser   // cycle_step
);

	cfg_t  cfg;
	logic  tick_clear;
	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	logic  out_valid_q;
	logic [NUM_CH-1:0][7:0] duty_d;
	logic [NUM_CH-1:0][7:0] duty_out_q;
	logic  step;
	logic  step_q;

	assign pready = 1'b1;

	rlcc_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.cfg        (cfg),
		.tick_clear (tick_clear)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd         <= s_axis_tuser[1:0];
			item_s1.channel_sel <= s_axis_tuser[3:2];
			item_s1.level       <= s_axis_tdata[7:0];
			item_s1.rgb_level   <= s_axis_tdata[31:8];
		end
	end

	rlcc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_clear (tick_clear),
		.item_valid (advance),
		.item       (item_s1),
		.duty_d     (duty_d),
		.step       (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_out_q <= duty_d;
			step_q     <= step;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = duty_out_q;
	assign m_axis_tuser  = step_q;

`ifndef SYNTHESIS
	// Only a timer tick can report a ramp step.
	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.cmd != CMD_TICK) |=> !m_axis_tuser)
		else $error("ramp step reported for a word that is not a tick");

	// No ramp step while cycling is disabled.
	a_step_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg.enable |=> !m_axis_tuser)
		else $error("ramp step reported with cycling disabled");

	// A word in the input register is never dropped while the result stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |=> valid_s1 && $stable(item_s1))
		else $error("input register lost its word during an output stall");

	// Every advance produces a result word in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("advanced word produced no result");
`endif

endmodule

@@ rtl/rlcc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rlcc_cfg_regs
// APB register file: channel gains, cycle speed and cycle enable.
// ----------------------------------------------------------------------------
module rlcc_cfg_regs import rlcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg,
	output logic        tick_clear
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx   = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain   <= {NUM_CH{FULL_SCALE}};
			cfg_q.speed  <= SPEED_AT_RESET;
			cfg_q.enable <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_RED_GAIN:    cfg_q.gain[CH_RED]   <= pwdata[7:0];
				REG_GREEN_GAIN:  cfg_q.gain[CH_GREEN] <= pwdata[7:0];
				REG_BLUE_GAIN:   cfg_q.gain[CH_BLUE]  <= pwdata[7:0];
				REG_CYCLE_SPEED: cfg_q.speed          <= pwdata[7:0];
				REG_CYCLE_EN:    cfg_q.enable         <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Disabling the cycle also clears the tick counter.
	assign tick_clear = wr_en && (idx == REG_CYCLE_EN) && !pwdata[0];
	assign cfg        = cfg_q;

	always_comb begin
		case (idx)
			REG_RED_GAIN:    prdata = {24'd0, cfg_q.gain[CH_RED]};
			REG_GREEN_GAIN:  prdata = {24'd0, cfg_q.gain[CH_GREEN]};
			REG_BLUE_GAIN:   prdata = {24'd0, cfg_q.gain[CH_BLUE]};
			REG_CYCLE_SPEED: prdata = {24'd0, cfg_q.speed};
			REG_CYCLE_EN:    prdata = {31'd0, cfg_q.enable};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/rlcc_engine.sv @@
// ----------------------------------------------------------------------------
// rlcc_engine
// Tick counter, ramp sequencer and scaled duty store. One word per cycle.
// ----------------------------------------------------------------------------
module rlcc_engine import rlcc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   tick_clear,
	input  logic                   item_valid,
	input  item_t                  item,
	output logic [NUM_CH-1:0][7:0] duty_d,
	output logic                   step
);

	logic [7:0]             tick_q;
	logic [7:0]             ramp_q;
	chan_t                  chan_q;
	logic                   down_q;
	logic [NUM_CH-1:0][7:0] duty_q;

	logic [7:0] period;
	logic [8:0] next_cnt;
	logic       hit;
	logic       is_tick;
	logic [7:0] ramp_d;
	chan_t      chan_d;
	chan_t      chan_inc;
	logic       down_d;

	assign period   = (cfg.speed == FULL_SCALE) ? 8'd1 : (FULL_SCALE - cfg.speed);
	assign next_cnt = {1'b0, tick_q} + 9'd1;
	assign hit      = next_cnt >= {1'b0, period};
	assign is_tick  = (item.cmd == CMD_TICK);
	assign step     = is_tick && cfg.enable && hit;
	assign chan_inc = (chan_q == CH_BLUE) ? CH_RED : (chan_q + 2'd1);

	// Ramp moves one count per step; at either end the channel advances instead.
	always_comb begin
		ramp_d = ramp_q;
		chan_d = chan_q;
		down_d = down_q;
		if (down_q) begin
			if (ramp_q != 8'd0) begin
				ramp_d = ramp_q - 8'd1;
			end else begin
				chan_d = chan_inc;
				down_d = 1'b0;
			end
		end else begin
			if (ramp_q != FULL_SCALE) begin
				ramp_d = ramp_q + 8'd1;
			end else begin
				chan_d = chan_inc;
				down_d = 1'b1;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			duty_d[c] = duty_q[c];
			case (item.cmd)
				CMD_TICK: begin
					if (step && (chan_q == 2'(c)))
						duty_d[c] = scale(ramp_q, cfg.gain[c]);
				end
				CMD_SET_ALL: begin
					duty_d[c] = scale(item.rgb_level[c], cfg.gain[c]);
				end
				CMD_SET_ONE: begin
					if (item.channel_sel == 2'(c))
						duty_d[c] = scale(item.level, cfg.gain[c]);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 8'd0;
			ramp_q <= 8'd0;
			chan_q <= CH_RED;
			down_q <= 1'b0;
			duty_q <= '0;
		end else begin
			if (tick_clear) begin
				tick_q <= 8'd0;
			end else if (item_valid && is_tick) begin
				if (!cfg.enable || hit)
					tick_q <= 8'd0;
				else
					tick_q <= next_cnt[7:0];
			end
			if (item_valid) begin
				duty_q <= duty_d;
				if (step) begin
					ramp_q <= ramp_d;
					chan_q <= chan_d;
					down_q <= down_d;
				end
			end
		end
	end

endmodule
